>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// Condition must never be true.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

>>> rtl/core/tmpc_pkg.sv
// ----------------------------------------------------------------------------
// tmpc_pkg
// Types, codes and arithmetic helpers of the teleoperation mode and clutch core.
// ----------------------------------------------------------------------------
package tmpc_pkg;

	localparam int POSE_BITS = 32;
	localparam int AXES      = 6;
	localparam int AXIS_BITS = $clog2(AXES);
	localparam int EV_BITS   = 4;
	localparam int MODE_BITS = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [AXIS_BITS-1:0] LAST_AXIS = AXIS_BITS'(AXES - 1);

	localparam int IN_RAW_BITS    = EV_BITS + AXES * POSE_BITS;
	localparam int IN_TDATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS   = 2 * MODE_BITS + EV_BITS + AXES * POSE_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	typedef logic signed [POSE_BITS-1:0] pose_t;
	typedef pose_t [AXES-1:0] pose_vec_t;

	localparam pose_t POSE_MAX = {1'b0, {(POSE_BITS-1){1'b1}}};
	localparam pose_t POSE_MIN = {1'b1, {(POSE_BITS-1){1'b0}}};

	typedef enum logic [MODE_BITS-1:0] {
		MODE_ENTRANCE  = 3'd0,
		MODE_READY     = 3'd1,
		MODE_INIT      = 3'd2,
		MODE_STOP      = 3'd3,
		MODE_RUN       = 3'd4,
		MODE_EMERGENCY = 3'd5,
		MODE_EXIT      = 3'd6
	} mode_t;

	localparam logic [EV_BITS-1:0] EV_NONE       = 4'd0;
	localparam logic [EV_BITS-1:0] EV_EXIT       = 4'd1;
	localparam logic [EV_BITS-1:0] EV_EMERGENCY  = 4'd2;
	localparam logic [EV_BITS-1:0] EV_START      = 4'd3;
	localparam logic [EV_BITS-1:0] EV_INIT       = 4'd4;
	localparam logic [EV_BITS-1:0] EV_STOP_START = 4'd5;
	localparam logic [EV_BITS-1:0] EV_STOP_STOP  = 4'd6;
	localparam logic [EV_BITS-1:0] EV_RUN_START  = 4'd7;
	localparam logic [EV_BITS-1:0] EV_RUN_STOP   = 4'd8;

	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_YAW   = 3'd5;

	// One axis step handed to the clutch unit.
	typedef struct packed {
		logic                 valid;
		logic [AXIS_BITS-1:0] axis;
		pose_t                cmd;
		mode_t                mode_now;
		mode_t                mode_before;
		logic [EV_BITS-1:0]   cause;
	} iss_t;

	// One finished axis coming back from the clutch unit.
	typedef struct packed {
		logic                 valid;
		logic [AXIS_BITS-1:0] axis;
		pose_t                value;
		mode_t                mode_now;
		mode_t                mode_before;
		logic [EV_BITS-1:0]   cause;
	} res_t;

	typedef struct packed {
		pose_t hold;
		pose_t off;
	} clutch_entry_t;

	function automatic pose_t sat_sub(pose_t a, pose_t b);
		logic signed [POSE_BITS:0] d;
		pose_t r;
		d = {a[POSE_BITS-1], a} - {b[POSE_BITS-1], b};
		if (d[POSE_BITS] != d[POSE_BITS-1]) begin
			r = d[POSE_BITS] ? POSE_MIN : POSE_MAX;
		end else begin
			r = d[POSE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tmpc_clutch.sv
// ----------------------------------------------------------------------------
// tmpc_clutch
// Per-axis clutch: reads hold pose and offset from a six-entry memory, forms
// the slave target for the axis and writes the entry back in the next cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmpc_clutch
	import tmpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  iss_t      iss,
	input  pose_vec_t origin,
	output res_t      res
);

	clutch_entry_t mem_q [AXES];
	logic [AXES-1:0] vld_q;

	logic                 v_s2;
	logic [AXIS_BITS-1:0] axis_s2;
	pose_t                cmd_s2;
	mode_t                mode_s2;
	mode_t                before_s2;
	logic [EV_BITS-1:0]   cause_s2;
	clutch_entry_t        rd_s2;
	logic                 vld_s2;

	pose_t         hold;
	pose_t         off;
	pose_t         off_new;
	pose_t         off_use;
	pose_t         r_sub;
	pose_t         result;
	clutch_entry_t wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= iss.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (iss.valid) begin
			axis_s2   <= iss.axis;
			cmd_s2    <= iss.cmd;
			mode_s2   <= iss.mode_now;
			before_s2 <= iss.mode_before;
			cause_s2  <= iss.cause;
			vld_s2    <= vld_q[iss.axis];
		end
	end

	// Synchronous memory: registered read, write-back from stage two.
	always_ff @(posedge clk) begin
		if (iss.valid) begin
			rd_s2 <= mem_q[iss.axis];
		end
		if (v_s2) begin
			mem_q[axis_s2] <= wr;
		end
	end

	// An entry never written reads as the zero reset pose.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (v_s2) begin
			vld_q[axis_s2] <= 1'b1;
		end
	end

	always_comb begin
		hold    = vld_s2 ? rd_s2.hold : '0;
		off     = vld_s2 ? rd_s2.off  : '0;
		off_new = sat_sub(cmd_s2, hold);
		off_use = (mode_s2 == MODE_RUN && before_s2 == MODE_STOP) ? off_new : off;
		r_sub   = sat_sub(cmd_s2, off_use);
		wr.hold = hold;
		wr.off  = off;
		result  = cmd_s2;
		if (mode_s2 == MODE_INIT) begin
			wr.hold = origin[axis_s2];
			result  = origin[axis_s2];
		end else if (mode_s2 == MODE_RUN && before_s2 == MODE_STOP) begin
			wr.off = off_new;
			result = r_sub;
		end else if (mode_s2 == MODE_RUN && before_s2 == MODE_RUN) begin
			result = r_sub;
		end else if (mode_s2 == MODE_STOP && before_s2 == MODE_RUN) begin
			result  = r_sub;
			wr.hold = r_sub;
		end else if (mode_s2 == MODE_STOP &&
				(before_s2 == MODE_STOP || before_s2 == MODE_INIT)) begin
			result = hold;
		end
	end

	assign res.valid       = v_s2;
	assign res.axis        = axis_s2;
	assign res.value       = result;
	assign res.mode_now    = mode_s2;
	assign res.mode_before = before_s2;
	assign res.cause       = cause_s2;

	// Reads and write-backs of one entry must never overlap.
	`ASSERT_NEVER(a_rw_collision, iss.valid && v_s2 && iss.axis == axis_s2)
	`ASSERT_IMPLIES(a_axis_range, iss.valid, iss.axis <= LAST_AXIS)
	`ASSERT_NEXT(a_entry_valid, v_s2, vld_q[$past(axis_s2)])

endmodule

>>> rtl/core/teleop_mode_fsm_with_pose_clutch_core.sv
// ----------------------------------------------------------------------------
// teleop_mode_fsm_with_pose_clutch_core
// Seven-state teleoperation mode machine with a six-axis saturating clutch.
// ----------------------------------------------------------------------------
// Path: an accepted beat goes to the work registers, then axis by axis through
// the single clutch read port to the assembly and output registers. A new beat
// is taken as the last axis issues; its axis zero waits for a free assembly register.
// Reset: all control state, mode registers and origin registers clear at once;
// clutch memory entries read as zero until first written, with no clearing pass.
`include "assert_macros.svh"

module teleop_mode_fsm_with_pose_clutch_core
	import tmpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// event_code, cmd_x, cmd_y, cmd_z, cmd_roll, cmd_pitch, cmd_yaw, zero fill
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// mode_now, mode_before, cause_event, out_x, out_y, out_z, out_roll,
	// out_pitch, out_yaw, zero fill
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [POSE_BITS-1:0]      cfg_wdata
);

	pose_vec_t origin_q;

	mode_t              mode_q;
	mode_t              prev_q;
	logic [EV_BITS-1:0] latch_q;
	logic               pend_q;
	mode_t              mode_d;
	mode_t              prev_d;
	logic [EV_BITS-1:0] latch_d;
	logic               pend_d;

	logic               accept;
	logic [EV_BITS-1:0] ev;
	pose_vec_t          cmd_in;

	pose_vec_t            work_cmd_q;
	mode_t                work_mode_q;
	mode_t                work_before_q;
	logic [EV_BITS-1:0]   work_cause_q;
	logic                 busy_q;
	logic [AXIS_BITS-1:0] cnt_q;

	iss_t iss;
	res_t res;

	pose_vec_t          asm_pose_q;
	mode_t              asm_mode_q;
	mode_t              asm_before_q;
	logic [EV_BITS-1:0] asm_cause_q;
	logic               asm_full_q;
	logic               move;
	logic               issue0_ok;

	pose_vec_t          out_pose_q;
	mode_t              out_mode_q;
	mode_t              out_before_q;
	logic [EV_BITS-1:0] out_cause_q;
	logic               m_valid_q;

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
		end else if (cfg_we && cfg_index inside {[REG_ORIGIN_X:REG_ORIGIN_YAW]}) begin
			origin_q[cfg_index] <= cfg_wdata;
		end
	end

	// Input unpacking.
	assign ev = s_axis_tdata[EV_BITS-1:0];
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cmd_in[a] = s_axis_tdata[EV_BITS + a*POSE_BITS +: POSE_BITS];
		end
	end

	assign s_axis_tready = !busy_q || cnt_q == LAST_AXIS;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Mode machine: next state. Exit and emergency win over every other rule.
	always_comb begin
		mode_d = mode_q;
		case (ev)
			EV_EXIT:      mode_d = MODE_EXIT;
			EV_EMERGENCY: mode_d = MODE_EMERGENCY;
			EV_START: begin
				if (mode_q inside {MODE_ENTRANCE, MODE_EMERGENCY}) mode_d = MODE_READY;
			end
			EV_INIT: begin
				if (mode_q inside {MODE_READY, MODE_EMERGENCY}) mode_d = MODE_INIT;
			end
			EV_STOP_START: begin
				if (mode_q inside {MODE_INIT, MODE_EMERGENCY}) mode_d = MODE_STOP;
			end
			EV_STOP_STOP: begin
				if (mode_q inside {MODE_STOP, MODE_EMERGENCY}) mode_d = MODE_READY;
			end
			EV_RUN_START: begin
				if (mode_q == MODE_STOP) mode_d = MODE_RUN;
			end
			EV_RUN_STOP: begin
				if (mode_q inside {MODE_RUN, MODE_EMERGENCY}) mode_d = MODE_STOP;
			end
			default: mode_d = mode_q;
		endcase
	end

	// Mode machine: reported previous mode and cause. The tick after a change
	// latches once more, then the report holds.
	always_comb begin
		prev_d  = prev_q;
		latch_d = latch_q;
		pend_d  = pend_q;
		if (mode_d != mode_q) begin
			prev_d  = mode_q;
			latch_d = ev;
			pend_d  = 1'b1;
		end else if (pend_q) begin
			prev_d  = mode_q;
			latch_d = ev;
			pend_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENTRANCE;
			prev_q  <= MODE_ENTRANCE;
			latch_q <= EV_START;
			pend_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			prev_q  <= prev_d;
			latch_q <= latch_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_cmd_q    <= cmd_in;
			work_mode_q   <= mode_d;
			work_before_q <= prev_d;
			work_cause_q  <= latch_d;
		end
	end

	// Axis sequencer. Axis zero of a new beat waits until the assembly
	// register will be free when its result lands.
	assign move      = asm_full_q && (!m_valid_q || m_axis_tready);
	assign issue0_ok = !(res.valid && res.axis == LAST_AXIS) && (!asm_full_q || move);

	always_comb begin
		iss.valid       = busy_q && (cnt_q != '0 || issue0_ok);
		iss.axis        = cnt_q;
		iss.cmd         = work_cmd_q[cnt_q];
		iss.mode_now    = work_mode_q;
		iss.mode_before = work_before_q;
		iss.cause       = work_cause_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (iss.valid) begin
			if (cnt_q == LAST_AXIS) begin
				cnt_q  <= '0;
				busy_q <= accept;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (!busy_q && accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end
	end

	tmpc_clutch u_clutch (
		.clk    (clk),
		.arst_n (arst_n),
		.iss    (iss),
		.origin (origin_q),
		.res    (res)
	);

	// Result assembly and output register.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			asm_pose_q[res.axis] <= res.value;
			asm_mode_q           <= res.mode_now;
			asm_before_q         <= res.mode_before;
			asm_cause_q          <= res.cause;
		end
		if (move) begin
			out_pose_q   <= asm_pose_q;
			out_mode_q   <= asm_mode_q;
			out_before_q <= asm_before_q;
			out_cause_q  <= asm_cause_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_full_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (res.valid && res.axis == LAST_AXIS) begin
				asm_full_q <= 1'b1;
			end else if (move) begin
				asm_full_q <= 1'b0;
			end
			if (move) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'({out_pose_q, out_cause_q, out_before_q, out_mode_q});

	// A new beat's first axis never lands on a still-full assembly register.
	`ASSERT_IMPLIES(a_asm_free, res.valid && res.axis == '0, !asm_full_q)
	`ASSERT_NEXT(a_asm_filled, res.valid && res.axis == LAST_AXIS, asm_full_q)
	`ASSERT_IMPLIES(a_issue_busy, iss.valid, busy_q)

endmodule
